>>> src/qrs_pkg.sv
// Package for the quadratic root solver: widths, status codes and the queue item type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package qrs_pkg;

  // Coefficient and fixed-point format.
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_W    = 33;

  // Derived widths.
  localparam int A_W    = COEF_BITS + 1;
  localparam int PROD_W = 2 * COEF_BITS;
  localparam int DS_W   = 2 * COEF_BITS + 2;
  localparam int D_W    = 2 * COEF_BITS + 1;
  localparam int RAD_W  = ((D_W + 2 * FRAC_BITS + 1) / 2) * 2;
  localparam int SQ_W   = RAD_W / 2;
  localparam int SREM_W = SQ_W + 2;
  localparam int NUM_W  = SQ_W + 2;
  localparam int DEN_W  = COEF_BITS + 1;
  localparam int DREM_W = DEN_W + 1;

  // Saturation limits on quotient magnitudes.
  localparam logic [NUM_W-1:0] ROOT_POS_LIM = NUM_W'((64'd1 << (ROOT_W - 1)) - 64'd1);
  localparam logic [NUM_W-1:0] ROOT_NEG_LIM = NUM_W'(64'd1 << (ROOT_W - 1));

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Status codes.
  localparam logic [1:0] ST_TWO   = 2'd0;
  localparam logic [1:0] ST_REP   = 2'd1;
  localparam logic [1:0] ST_CPLX  = 2'd2;
  localparam logic [1:0] ST_AZERO = 2'd3;

  // One classified equation, as it waits in the queue.
  typedef struct packed {
    logic [1:0]                  status;
    logic [D_W-1:0]              dmag;
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
  } qrs_item_t;

endpackage

`default_nettype wire

>>> src/qrs_front.sv
// Front part: accepts coefficient triples, forms the discriminant and classifies.
// Depends on qrs_pkg; feeds qrs_fifo.
`default_nettype none

module qrs_front import qrs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COEF_BITS-1:0] coef_a,
  input  logic signed [COEF_BITS-1:0] coef_b,
  input  logic signed [COEF_BITS-1:0] coef_c,
  output logic                        push,
  output qrs_item_t                   push_item,
  input  logic                        full
);

  logic                        en;
  logic                        f1_valid;
  logic signed [COEF_BITS-1:0] f1_a;
  logic signed [COEF_BITS-1:0] f1_b;
  logic signed [PROD_W-1:0]    f1_bb;
  logic signed [PROD_W-1:0]    f1_ac;
  logic                        f2_valid;
  qrs_item_t                   f2_item;
  logic signed [DS_W-1:0]      d;
  qrs_item_t                   item_next;

  // The pipeline moves unless its last item cannot enter the queue.
  assign en       = !f2_valid || !full;
  assign in_stall = !en;
  assign push     = f2_valid && !full;
  assign push_item = f2_item;

  // Discriminant and classification.
  always_comb begin
    d = DS_W'(f1_bb) - (DS_W'(f1_ac) <<< 2);
    item_next.coef_a = f1_a;
    item_next.coef_b = f1_b;
    item_next.dmag   = '0;
    if (f1_a == '0) begin
      item_next.status = ST_AZERO;
    end else if (d < 0) begin
      item_next.status = ST_CPLX;
    end else if (d == '0) begin
      item_next.status = ST_REP;
    end else begin
      item_next.status = ST_TWO;
      item_next.dmag   = d[D_W-1:0];
    end
  end

  // Product stage, then classification stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_a     <= coef_a;
      f1_b     <= coef_b;
      f1_bb    <= coef_b * coef_b;
      f1_ac    <= coef_a * coef_c;
      f2_item  <= item_next;
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

endmodule

`default_nettype wire

>>> src/qrs_fifo.sv
// Short queue between front and back parts of the root solver.
// Depends on qrs_pkg for the item type and depth.
`default_nettype none

module qrs_fifo import qrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  qrs_item_t push_item,
  output logic      full,
  input  logic      pop,
  output qrs_item_t pop_item,
  output logic      empty
);

  qrs_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The front never writes into a full queue, the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

endmodule

`default_nettype wire

>>> src/qrs_back.sv
// Back part: pipelined square root, two pipelined dividers and the result register.
// Depends on qrs_pkg; reads from qrs_fifo.
`default_nettype none

module qrs_back import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  qrs_item_t                pop_item,
  input  logic                     empty,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [ROOT_W-1:0] root_plus,
  output logic signed [ROOT_W-1:0] root_minus
);

  typedef struct packed {
    logic                        valid;
    logic [1:0]                  status;
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic [RAD_W-1:0]            rad;
    logic [SREM_W-1:0]           rem;
    logic [SQ_W-1:0]             root;
  } sq_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic              neg_p;
    logic              neg_m;
    logic [NUM_W-1:0]  num_p;
    logic [NUM_W-1:0]  num_m;
    logic [DEN_W-1:0]  den;
    logic [DREM_W-1:0] rem_p;
    logic [DREM_W-1:0] rem_m;
    logic [NUM_W-1:0]  q_p;
    logic [NUM_W-1:0]  q_m;
  } dv_t;

  // One result bit of the square root.
  function automatic sq_t sq_step(sq_t s);
    sq_t               r;
    logic [SREM_W-1:0] rs;
    logic [SREM_W-1:0] trial;
    r     = s;
    rs    = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {s.root, 2'b01};
    r.rad = s.rad << 2;
    if (rs >= trial) begin
      r.rem  = rs - trial;
      r.root = {s.root[SQ_W-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {s.root[SQ_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of each restoring division.
  function automatic dv_t dv_step(dv_t s);
    dv_t               r;
    logic [DREM_W-1:0] rp;
    logic [DREM_W-1:0] rm;
    r       = s;
    rp      = {s.rem_p[DREM_W-2:0], s.num_p[NUM_W-1]};
    rm      = {s.rem_m[DREM_W-2:0], s.num_m[NUM_W-1]};
    r.num_p = s.num_p << 1;
    r.num_m = s.num_m << 1;
    if (rp >= DREM_W'(s.den)) begin
      r.rem_p = rp - DREM_W'(s.den);
      r.q_p   = {s.q_p[NUM_W-2:0], 1'b1};
    end else begin
      r.rem_p = rp;
      r.q_p   = {s.q_p[NUM_W-2:0], 1'b0};
    end
    if (rm >= DREM_W'(s.den)) begin
      r.rem_m = rm - DREM_W'(s.den);
      r.q_m   = {s.q_m[NUM_W-2:0], 1'b1};
    end else begin
      r.rem_m = rm;
      r.q_m   = {s.q_m[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Signed, saturated root from quotient magnitude.
  function automatic logic [ROOT_W-1:0] pack_root(logic neg, logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0] lim;
    logic [NUM_W-1:0] m;
    lim = neg ? ROOT_NEG_LIM : ROOT_POS_LIM;
    m   = (mag > lim) ? lim : mag;
    return neg ? -m[ROOT_W-1:0] : m[ROOT_W-1:0];
  endfunction

  logic                    en;
  sq_t                     sq [SQ_W+1];
  dv_t                     dv [NUM_W+1];
  sq_t                     sq_load;
  dv_t                     dv_load;
  logic signed [NUM_W-1:0] nb;
  logic signed [NUM_W-1:0] sv;
  logic signed [NUM_W-1:0] np;
  logic signed [NUM_W-1:0] nm;
  logic signed [A_W-1:0]   ax;
  logic [A_W-1:0]          amag;
  logic                    zero_out;

  // The whole back pipeline advances whenever the result register can take a transfer.
  assign en  = !out_valid || !out_stall;
  assign pop = en && !empty;

  // Entry of the square-root pipeline: D scaled by two fraction widths.
  always_comb begin
    sq_load.valid  = !empty;
    sq_load.status = pop_item.status;
    sq_load.coef_a = pop_item.coef_a;
    sq_load.coef_b = pop_item.coef_b;
    sq_load.rad    = RAD_W'(pop_item.dmag) << (2 * FRAC_BITS);
    sq_load.rem    = '0;
    sq_load.root   = '0;
  end

  // Numerators and divisor magnitudes for the two divisions.
  always_comb begin
    nb   = -(NUM_W'(sq[SQ_W].coef_b) <<< FRAC_BITS);
    sv   = NUM_W'(sq[SQ_W].root);
    np   = nb + sv;
    nm   = nb - sv;
    ax   = A_W'(sq[SQ_W].coef_a);
    amag = ax[A_W-1] ? A_W'(-ax) : A_W'(ax);
    dv_load.valid  = sq[SQ_W].valid;
    dv_load.status = sq[SQ_W].status;
    dv_load.neg_p  = np[NUM_W-1] ^ ax[A_W-1];
    dv_load.neg_m  = nm[NUM_W-1] ^ ax[A_W-1];
    dv_load.num_p  = np[NUM_W-1] ? NUM_W'(-np) : NUM_W'(np);
    dv_load.num_m  = nm[NUM_W-1] ? NUM_W'(-nm) : NUM_W'(nm);
    dv_load.den    = {amag[COEF_BITS-1:0], 1'b0};
    dv_load.rem_p  = '0;
    dv_load.rem_m  = '0;
    dv_load.q_p    = '0;
    dv_load.q_m    = '0;
  end

  assign zero_out = (dv[NUM_W].status == ST_CPLX) || (dv[NUM_W].status == ST_AZERO);

  // Pipeline registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_W; k++) begin
        sq[k].valid <= 1'b0;
      end
      for (int k = 0; k <= NUM_W; k++) begin
        dv[k].valid <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      sq[0] <= sq_load;
      for (int k = 0; k < SQ_W; k++) begin
        sq[k+1] <= sq_step(sq[k]);
      end
      dv[0] <= dv_load;
      for (int k = 0; k < NUM_W; k++) begin
        dv[k+1] <= dv_step(dv[k]);
      end
      out_valid  <= dv[NUM_W].valid;
      status     <= dv[NUM_W].status;
      root_plus  <= zero_out ? '0 : pack_root(dv[NUM_W].neg_p, dv[NUM_W].q_p);
      root_minus <= zero_out ? '0 : pack_root(dv[NUM_W].neg_m, dv[NUM_W].q_m);
    end
  end

  // Results without real roots carry zero; a repeated root appears in both fields.
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
      out_valid && (status == ST_CPLX || status == ST_AZERO)
      |-> root_plus == '0 && root_minus == '0)
    else $error("nonzero root on a result without real roots");
  a_rep_equal: assert property (@(posedge clk) disable iff (rst)
      out_valid && status == ST_REP |-> root_plus == root_minus)
    else $error("repeated root differs between fields");

endmodule

`default_nettype wire

>>> src/quadratic_root_solver.sv
// Top level of the quadratic root solver: front classifier, queue and root back end.
// Depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back.
//
//   Channel  Handshake            Payload
//   input    in_valid, in_stall   coef_a, coef_b, coef_c
//   output   out_valid, out_stall status, root_plus, root_minus
//
// One equation enters and one result leaves per cycle, sustained while the output
// is not stalled. An equation passes two front stages, the queue write, the load
// stage, 33 square-root stages (one root bit per stage), 36 divider stages (the first
// loads the numerators, then one quotient bit per stage) and the result register.
// Reset is synchronous and clears all valid flags and the queue. A stalled output
// holds the back pipeline; the front keeps accepting until the four-entry queue fills.
`default_nettype none

module quadratic_root_solver import qrs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COEF_BITS-1:0] coef_a,
  input  logic signed [COEF_BITS-1:0] coef_b,
  input  logic signed [COEF_BITS-1:0] coef_c,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic signed [ROOT_W-1:0]    root_plus,
  output logic signed [ROOT_W-1:0]    root_minus
);

  logic      push;
  logic      full;
  logic      pop;
  logic      empty;
  qrs_item_t push_item;
  qrs_item_t pop_item;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  qrs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  qrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_item   (pop_item),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .root_plus  (root_plus),
    .root_minus (root_minus)
  );

endmodule

`default_nettype wire

>>> tb/quadratic_root_solver_tb.sv
// Testbench for the quadratic root solver: drives coefficient triples, predicts
// status and Q.16 roots, and checks every result. Depends on qrs_pkg and the RTL.
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int LATENCY   = 74;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    logic [1:0]               status;
    logic signed [ROOT_W-1:0] root_plus;
    logic signed [ROOT_W-1:0] root_minus;
  } roots_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [COEF_BITS-1:0] coef_a;
  logic signed [COEF_BITS-1:0] coef_b;
  logic signed [COEF_BITS-1:0] coef_c;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic signed [ROOT_W-1:0] root_plus;
  logic signed [ROOT_W-1:0] root_minus;

  roots_t pending_roots[$];
  int     error_count;
  int     sent_count;
  int     result_count;
  int     cycle_count;
  int     status_seen[4];
  bit     idle_enable;
  bit     hold_off;

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .root_plus(root_plus), .root_minus(root_minus)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Integer square root of a 128-bit value, floor.
  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int bitpos = 63; bitpos >= 0; bitpos--) begin
      cand = r | (64'd1 << bitpos);
      sq = 128'(cand) * 128'(cand);
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  // Saturate a quotient to the root width.
  function automatic logic signed [ROOT_W-1:0] clamp_root(longint v);
    longint hi;
    hi = (longint'(1) <<< (ROOT_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return ROOT_W'(v);
  endfunction

  // Predict status and both roots for one equation.
  function automatic roots_t solve_roots(logic signed [COEF_BITS-1:0] a,
                                         logic signed [COEF_BITS-1:0] b,
                                         logic signed [COEF_BITS-1:0] c);
    roots_t r;
    longint la, lb, lc, disc, sq, nb, den;
    la = a;
    lb = b;
    lc = c;
    sq = 0;
    r.root_plus  = '0;
    r.root_minus = '0;
    if (la == 0) begin
      r.status = ST_AZERO;
      return r;
    end
    disc = lb * lb - 4 * la * lc;
    if (disc < 0) begin
      r.status = ST_CPLX;
      return r;
    end
    r.status = (disc == 0) ? ST_REP : ST_TWO;
    if (disc > 0) sq = longint'(floor_sqrt(128'(disc) << (2 * FRAC_BITS)));
    nb  = -lb * (longint'(1) <<< FRAC_BITS);
    den = 2 * la;
    r.root_plus  = clamp_root((nb + sq) / den);
    r.root_minus = clamp_root((nb - sq) / den);
    return r;
  endfunction

  // Offer one equation and wait for its transfer.
  task automatic send_equation(logic signed [COEF_BITS-1:0] a,
                               logic signed [COEF_BITS-1:0] b,
                               logic signed [COEF_BITS-1:0] c);
    while (idle_enable && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coef_a   <= a;
    coef_b   <= b;
    coef_c   <= c;
    pending_roots.push_back(solve_roots(a, b, c));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Extremes of the fields and every status case.
  task automatic test_directed();
    send_equation(16'sd0, 16'sd5, 16'sd3);
    send_equation(16'sd0, 16'sd0, 16'sd0);
    send_equation(16'sd1, 16'sd0, 16'sd1);
    send_equation(16'sd1, -16'sd2, 16'sd1);
    send_equation(16'sd1, 16'sd0, -16'sd1);
    send_equation(16'sd1, -16'sd3, 16'sd2);
    send_equation(16'sd1, 16'sd0, 16'sd0);
    send_equation(16'sd2, 16'sd0, -16'sd1);
    send_equation(-16'sd32768, -16'sd32768, -16'sd32768);
    send_equation(-16'sd32768, -16'sd32768, 16'sd32767);
    send_equation(16'sd32767, 16'sd32767, -16'sd32768);
    send_equation(16'sd32767, 16'sd32767, 16'sd32767);
    send_equation(16'sd1, -16'sd32768, -16'sd32768);
    send_equation(-16'sd1, 16'sd32767, 16'sd32767);
    send_equation(16'sd1, -16'sd32768, 16'sd0);
    send_equation(-16'sd1, 16'sd0, 16'sd32767);
    send_equation(16'sd1, 16'sd32767, 16'sd0);
    send_equation(16'sd4, 16'sd4, 16'sd1);
    send_equation(-16'sd1, 16'sd0, -16'sd1);
    send_equation(16'sd3, 16'sd1, -16'sd5);
    end_burst();
  endtask

  // Random coefficients, mixing full range with small values and perfect squares.
  task automatic test_random(int count);
    logic signed [COEF_BITS-1:0] a, b, c;
    int p, q;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          a = COEF_BITS'($urandom);
          b = COEF_BITS'($urandom);
          c = COEF_BITS'($urandom);
        end
        1: begin
          a = $signed(16'($urandom_range(40))) - 16'sd20;
          b = $signed(16'($urandom_range(200))) - 16'sd100;
          c = $signed(16'($urandom_range(200))) - 16'sd100;
        end
        2: begin
          // Repeated root: a*(x-p)^2 scaled to stay in range.
          a = $signed(16'($urandom_range(9))) - 16'sd4;
          p = int'($urandom_range(40)) - 20;
          b = COEF_BITS'(-2 * a * p);
          c = COEF_BITS'(a * p * p);
        end
        default: begin
          // Two integer roots p and q.
          a = ($urandom_range(1)) ? 16'sd1 : -16'sd1;
          p = int'($urandom_range(200)) - 100;
          q = int'($urandom_range(200)) - 100;
          b = COEF_BITS'(-a * (p + q));
          c = COEF_BITS'(a * p * q);
        end
      endcase
      send_equation(a, b, c);
    end
    end_burst();
  endtask

  // Receiver holds off for a long stretch while items keep arriving.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
  endtask

  // Checker for each result transfer.
  always @(posedge clk) begin
    roots_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pending_roots.size() == 0) begin
        $error("result with no equation outstanding");
        error_count++;
      end else begin
        want = pending_roots.pop_front();
        status_seen[status]++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          error_count++;
        end
        if (root_plus !== want.root_plus) begin
          $error("root_plus: expected %0d, actual %0d", want.root_plus, root_plus);
          error_count++;
        end
        if (root_minus !== want.root_minus) begin
          $error("root_minus: expected %0d, actual %0d", want.root_minus, root_minus);
          error_count++;
        end
      end
    end
  end

  // Receiver stall, random or held during the backpressure test.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || (idle_enable && $urandom_range(99) < 25);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    coef_a      = '0;
    coef_b      = '0;
    coef_c      = '0;
    idle_enable = 1'b1;
    hold_off    = 1'b0;
    error_count = 0;
    sent_count  = 0;
    result_count = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200);
    idle_enable = 1'b0;
    test_random(100);
    idle_enable = 1'b1;
    test_backpressure();
    test_random(160);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d equations, checked %0d results.", sent_count, result_count);
    $display("Status counts: two %0d, repeated %0d, complex %0d, a zero %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
